// ----- hw/rtl/pca_pkg.sv -----
package pca_pkg;

  localparam int PIX_W         = 8;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 5;
  localparam int FRAC_BITS_DEF = 12;

  localparam int SHIFT_W    = 14;
  localparam int GAIN_W     = 15;
  localparam int SHIFT_LIM  = 4096;
  localparam int GAIN_LIM   = 16384;
  localparam int GAIN_RESET = 4096;

  localparam int LUM_DEN = 10000;
  localparam logic signed [15:0] LUM_WEIGHT [3] = '{16'sd2126, 16'sd7152, 16'sd722};
  localparam logic signed [15:0] LUM_DEN_S = 16'(LUM_DEN);

  // floor(n / 10000) = (n * RECIP_MUL) >> RECIP_SHIFT, exact for n < 2**QN_W
  localparam int QN_W        = 22;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 23'd6871948;
  localparam int QUOT_LIM    = 256 * LUM_DEN;

  typedef enum logic [2:0] {
    REG_BRIGHT   = 3'd0,
    REG_CONTRAST = 3'd1,
    REG_SAT      = 3'd2,
    REG_TEMP     = 3'd3,
    REG_TINT     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] brightness;
    logic        [GAIN_W-1:0]  contrast;
    logic        [GAIN_W-1:0]  saturation;
    logic signed [SHIFT_W-1:0] temperature;
    logic signed [SHIFT_W-1:0] tint;
    logic                      bypass;
  } pca_cfg_t;

endpackage

// ----- hw/rtl/pca_stream_ifs.sv -----
interface pca_in_if;
  import pca_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] alpha_in;
  logic             last_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, last_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, last_in, output ready);
endinterface

interface pca_out_if;
  import pca_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] alpha_out;
  logic             last_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_out, output ready);
endinterface

// ----- hw/rtl/pca_pipe.sv -----
module pca_pipe #(
  parameter int FRAC_BITS = pca_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pca_pkg::pca_cfg_t cfg,
  pca_in_if.sink            in_px,
  pca_out_if.source         out_px
);
  import pca_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int NS  = 9;
  localparam int XW  = F + 14;
  localparam int MW  = XW + GAIN_W + 1;
  localparam int PW  = XW + 19;
  localparam int VW  = PW - F - 2;
  localparam int LW  = VW + 16;
  localparam int DW  = LW + 1;
  localparam int NW  = DW + GAIN_W + 1;
  localparam int PQW = QN_W + RECIP_W;

  localparam logic signed [XW-1:0] HALF_X = XW'(255 * (2 ** (F - 1)));
  localparam logic signed [VW-1:0] HALF_V = VW'(255 * (2 ** (F - 1)));

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             last;
  } side_t;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  side_t         side_r [NS];

  logic        [PIX_W-1:0] chan     [3];
  logic        [PIX_W-1:0] byp      [3];
  logic signed [XW-1:0]    dx_nxt   [3];
  logic signed [XW-1:0]    dx_r     [3];
  logic signed [MW-1:0]    prod_nxt [3];
  logic signed [MW-1:0]    prod_r   [3];
  logic signed [PW-1:0]    shft     [3];
  logic signed [PW-1:0]    acc      [3];
  logic signed [PW-1:0]    acc_sh   [3];
  logic signed [VW-1:0]    pre_nxt  [3];
  logic signed [VW-1:0]    pre_r    [3];
  logic signed [LW-1:0]    lw_nxt   [3];
  logic signed [LW-1:0]    lw_r     [3];
  logic signed [LW-1:0]    v10k_nxt [3];
  logic signed [LW-1:0]    v10k_r   [3];
  logic signed [LW-1:0]    lum_nxt;
  logic signed [LW-1:0]    lum_r;
  logic signed [DW-1:0]    d_nxt    [3];
  logic signed [DW-1:0]    d_r      [3];
  logic signed [NW-1:0]    lumone_nxt;
  logic signed [NW-1:0]    lumone_r;
  logic signed [NW-1:0]    dsat_nxt [3];
  logic signed [NW-1:0]    dsat_r   [3];
  logic signed [NW-1:0]    num      [3];
  logic signed [NW-1:0]    nsh      [3];
  logic        [QN_W-1:0]  nq_nxt   [3];
  logic        [QN_W-1:0]  nq_r     [3];
  logic        [2:0]       neg_nxt, over_nxt, neg_r, over_r, neg2_r, over2_r;
  logic        [PQW-1:0]   pq_nxt   [3];
  logic        [PQW-1:0]   pq_r     [3];
  logic        [PIX_W-1:0] res_nxt  [3];
  logic        [PIX_W-1:0] res_r    [3];

  logic signed [XW-1:0] b_x, b255;
  logic signed [PW-1:0] t_p, n_p, t153, n153;
  side_t                side_in;

  // ready backs up stage by stage, bubbles are absorbed
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_px.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_px.ready = en[0];

  assign chan[0] = in_px.red_in;
  assign chan[1] = in_px.green_in;
  assign chan[2] = in_px.blue_in;
  assign side_in = '{red: in_px.red_in, green: in_px.green_in, blue: in_px.blue_in,
                     alpha: in_px.alpha_in, last: in_px.last_in};

  assign byp[0] = side_r[NS-2].red;
  assign byp[1] = side_r[NS-2].green;
  assign byp[2] = side_r[NS-2].blue;

  assign b_x  = XW'(cfg.brightness);
  assign b255 = (b_x <<< 8) - b_x;
  assign t_p  = PW'(cfg.temperature);
  assign n_p  = PW'(cfg.tint);
  assign t153 = (t_p <<< 7) + (t_p <<< 4) + (t_p <<< 3) + t_p;
  assign n153 = (n_p <<< 7) + (n_p <<< 4) + (n_p <<< 3) + n_p;

  // per-channel shift at scale 4*255*ONE*ONE
  assign shft[0] = t153 <<< F;
  assign shft[1] = -(n153 <<< F);
  assign shft[2] = -(t153 <<< F);

  always_comb begin
    lum_nxt    = lw_r[0] + lw_r[1] + lw_r[2];
    lumone_nxt = NW'(lum_r) <<< F;
    for (int c = 0; c < 3; c++) begin
      dx_nxt[c]   = $signed(XW'({chan[c], {F{1'b0}}})) + b255 - HALF_X;
      prod_nxt[c] = dx_r[c] * $signed({1'b0, cfg.contrast});
      acc[c]      = (PW'(prod_r[c]) <<< 2) + shft[c];
      acc_sh[c]   = acc[c] >>> (F + 2);
      pre_nxt[c]  = $signed(acc_sh[c][VW-1:0]) + HALF_V;
      lw_nxt[c]   = LW'(pre_r[c]) * LUM_WEIGHT[c];
      v10k_nxt[c] = LW'(pre_r[c]) * LUM_DEN_S;
      d_nxt[c]    = DW'(v10k_r[c]) - DW'(lum_nxt);
      dsat_nxt[c] = NW'(d_r[c]) * $signed({1'b0, cfg.saturation});
      num[c]      = lumone_r + dsat_r[c];
      nsh[c]      = num[c] >>> (2 * F);
      neg_nxt[c]  = num[c][NW-1];
      over_nxt[c] = !num[c][NW-1] && (nsh[c][NW-2:0] >= (NW-1)'(QUOT_LIM));
      nq_nxt[c]   = nsh[c][QN_W-1:0];
      pq_nxt[c]   = PQW'(nq_r[c]) * PQW'(RECIP_MUL);
      if (cfg.bypass) begin
        res_nxt[c] = byp[c];
      end else if (neg2_r[c]) begin
        res_nxt[c] = '0;
      end else if (over2_r[c]) begin
        res_nxt[c] = '1;
      end else begin
        res_nxt[c] = pq_r[c][RECIP_SHIFT +: PIX_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_px.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_in;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (en[0]) dx_r[c]   <= dx_nxt[c];
      if (en[1]) prod_r[c] <= prod_nxt[c];
      if (en[2]) pre_r[c]  <= pre_nxt[c];
      if (en[3]) begin
        lw_r[c]   <= lw_nxt[c];
        v10k_r[c] <= v10k_nxt[c];
      end
      if (en[4]) d_r[c]    <= d_nxt[c];
      if (en[5]) dsat_r[c] <= dsat_nxt[c];
      if (en[6]) nq_r[c]   <= nq_nxt[c];
      if (en[7]) pq_r[c]   <= pq_nxt[c];
      if (en[8]) res_r[c]  <= res_nxt[c];
    end
    if (en[4]) lum_r    <= lum_nxt;
    if (en[5]) lumone_r <= lumone_nxt;
    if (en[6]) begin
      neg_r  <= neg_nxt;
      over_r <= over_nxt;
    end
    if (en[7]) begin
      neg2_r  <= neg_r;
      over2_r <= over_r;
    end
  end

  assign out_px.valid     = v_r[NS-1];
  assign out_px.red_out   = res_r[0];
  assign out_px.green_out = res_r[1];
  assign out_px.blue_out  = res_r[2];
  assign out_px.alpha_out = side_r[NS-1].alpha;
  assign out_px.last_out  = side_r[NS-1].last;

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_px.valid && in_px.ready |=> v_r[0])
    else $error("accepted pixel not captured in first stage");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_px.ready |-> (&v_r))
    else $error("input stalled while pipeline has a bubble");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] && !neg2_r[0] && !over2_r[0] && !neg2_r[1] && !over2_r[1]
      && !neg2_r[2] && !over2_r[2]
    |-> (pq_r[0][PQW-1:RECIP_SHIFT+PIX_W] == '0) && (pq_r[1][PQW-1:RECIP_SHIFT+PIX_W] == '0)
      && (pq_r[2][PQW-1:RECIP_SHIFT+PIX_W] == '0))
    else $error("in-range quotient exceeds pixel range");

endmodule

// ----- hw/rtl/pixel_color_adjust_core.sv -----
// Color grading of an RGBA pixel stream: brightness, contrast about mid grey,
// temperature/tint shift and saturation about Rec.709 luminance.
// in_px: one pixel per transfer (red_in, green_in, blue_in, alpha_in, last_in).
// out_px: one graded pixel per transfer, in order; alpha and last ride along.
// Settings via APB (psel/penable/pwrite/paddr/pwdata, pready tied high):
//   0x00 brightness, 0x04 contrast, 0x08 saturation, 0x0C temperature, 0x10 tint.
//   Q.FRAC_BITS fixed point; out-of-range writes saturate. Write only while idle.
// Nine register stages lie between an input transfer and its output transfer:
//   offset, contrast multiply, shift, luminance weights, luminance sum,
//   saturation multiply, scale and clamp check, reciprocal multiply, output.
// Throughput: one pixel per clock while out_px.ready is high.
// When out_px.ready is low, each stage holds; ready propagates back stage by
// stage, so empty stages keep filling and in_px.ready drops only when all
// nine stages hold pixels.
// Reset: pipeline valid bits clear, settings return to defaults (pixels then
// pass through unchanged).
module pixel_color_adjust_core #(
  parameter int FRAC_BITS = pca_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pca_in_if.sink                      in_px,
  pca_out_if.source                   out_px,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pca_pkg::ADDR_W-1:0]  paddr,
  input  logic [pca_pkg::DATA_W-1:0]  pwdata,
  output logic [pca_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import pca_pkg::*;

  localparam int ONE = 2 ** FRAC_BITS;
  localparam int TOL = (ONE - 1) / 1000;
  localparam logic signed [SHIFT_W-1:0] TOL_HI = SHIFT_W'(TOL);
  localparam logic signed [SHIFT_W-1:0] TOL_LO = SHIFT_W'(-TOL);
  localparam logic [DATA_W-1:0] GAIN_LO = DATA_W'(ONE - TOL);
  localparam logic [DATA_W-1:0] GAIN_HI = DATA_W'(ONE + TOL);
  localparam logic signed [SHIFT_W-1:0] S_MAX = SHIFT_W'(SHIFT_LIM);
  localparam logic signed [SHIFT_W-1:0] S_MIN = SHIFT_W'(-SHIFT_LIM);
  localparam logic [GAIN_W-1:0] G_MAX = GAIN_W'(GAIN_LIM);

  logic signed [SHIFT_W-1:0] brightness_r, brightness_nxt;
  logic        [GAIN_W-1:0]  contrast_r, contrast_nxt;
  logic        [GAIN_W-1:0]  saturation_r, saturation_nxt;
  logic signed [SHIFT_W-1:0] temperature_r, temperature_nxt;
  logic signed [SHIFT_W-1:0] tint_r, tint_nxt;

  logic                      wr;
  reg_idx_t                  idx;
  logic signed [SHIFT_W-1:0] wr_s;
  logic signed [SHIFT_W-1:0] wr_s_sat;
  logic        [GAIN_W-1:0]  wr_g;
  logic        [GAIN_W-1:0]  wr_g_sat;
  logic                      near_def;
  pca_cfg_t                  cfg;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign idx      = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_s     = $signed(pwdata[SHIFT_W-1:0]);
  assign wr_g     = pwdata[GAIN_W-1:0];
  assign wr_s_sat = (wr_s > S_MAX) ? S_MAX : ((wr_s < S_MIN) ? S_MIN : wr_s);
  assign wr_g_sat = (wr_g > G_MAX) ? G_MAX : wr_g;

  always_comb begin
    brightness_nxt  = brightness_r;
    contrast_nxt    = contrast_r;
    saturation_nxt  = saturation_r;
    temperature_nxt = temperature_r;
    tint_nxt        = tint_r;
    if (wr) begin
      case (idx)
        REG_BRIGHT:   brightness_nxt  = wr_s_sat;
        REG_CONTRAST: contrast_nxt    = wr_g_sat;
        REG_SAT:      saturation_nxt  = wr_g_sat;
        REG_TEMP:     temperature_nxt = wr_s_sat;
        REG_TINT:     tint_nxt        = wr_s_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r  <= '0;
      contrast_r    <= GAIN_W'(GAIN_RESET);
      saturation_r  <= GAIN_W'(GAIN_RESET);
      temperature_r <= '0;
      tint_r        <= '0;
    end else begin
      brightness_r  <= brightness_nxt;
      contrast_r    <= contrast_nxt;
      saturation_r  <= saturation_nxt;
      temperature_r <= temperature_nxt;
      tint_r        <= tint_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_BRIGHT:   prdata = DATA_W'(brightness_r);
      REG_CONTRAST: prdata = DATA_W'(contrast_r);
      REG_SAT:      prdata = DATA_W'(saturation_r);
      REG_TEMP:     prdata = DATA_W'(temperature_r);
      REG_TINT:     prdata = DATA_W'(tint_r);
      default:      prdata = '0;
    endcase
  end

  // every setting within 0.001 of its default: pass pixels untouched
  assign near_def = (brightness_r >= TOL_LO) && (brightness_r <= TOL_HI)
                 && (temperature_r >= TOL_LO) && (temperature_r <= TOL_HI)
                 && (tint_r >= TOL_LO) && (tint_r <= TOL_HI)
                 && (DATA_W'(contrast_r) >= GAIN_LO) && (DATA_W'(contrast_r) <= GAIN_HI)
                 && (DATA_W'(saturation_r) >= GAIN_LO) && (DATA_W'(saturation_r) <= GAIN_HI);

  assign cfg = '{brightness: brightness_r, contrast: contrast_r, saturation: saturation_r,
                 temperature: temperature_r, tint: tint_r, bypass: near_def};

  pca_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_px  (in_px),
    .out_px (out_px)
  );

  a_bright_sat: assert property (@(posedge clk) disable iff (!rst_n)
    wr && idx == REG_BRIGHT |=> (brightness_r <= S_MAX) && (brightness_r >= S_MIN))
    else $error("brightness write not saturated");

  a_sat_sat: assert property (@(posedge clk) disable iff (!rst_n)
    wr && idx == REG_SAT |=> saturation_r <= G_MAX)
    else $error("saturation write not saturated");

  a_contrast_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && idx == REG_CONTRAST) |=> $stable(contrast_r))
    else $error("contrast changed without a write to it");

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pca_pkg::*;

  localparam int         FRAC        = FRAC_BITS_DEF;
  localparam longint     ONE         = longint'(1) << FRAC;
  localparam longint     HALF_GREY   = 255 * ONE / 2;
  localparam longint     SHIFT_K     = 153;
  localparam longint     W_RED       = 2126;
  localparam longint     W_GREEN     = 7152;
  localparam longint     W_BLUE      = 722;
  localparam longint     W_DEN       = 10000;
  localparam logic [2:0] REG_SPARE   = 3'd5;
  localparam int         IDLE_LIMIT  = 2000;
  localparam int         TAIL_CYCLES = 20;
  localparam int         PHASES      = 9;
  localparam int         PHASE_ITEMS = 50;
  localparam int         HOLD_CYCLES = 80;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } pixel_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  sel;
    logic [31:0] wdata;
    pixel_t      px;
    bit          known;
    pixel_t      known_px;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pca_in_if  in_if ();
  pca_out_if out_if ();

  pixel_color_adjust_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (in_if),
    .out_px  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [SHIFT_W-1:0] set_bright;
  logic        [GAIN_W-1:0]  set_contrast;
  logic        [GAIN_W-1:0]  set_sat;
  logic signed [SHIFT_W-1:0] set_temp;
  logic signed [SHIFT_W-1:0] set_tint;

  pixel_t    graded_q[$];
  step_row_t dir_steps[$];
  int        errors       = 0;
  int        results_seen = 0;
  int        idle_cycles  = 0;
  int        stall_left   = 0;
  int        hold_req     = 0;
  bit        quiet        = 1'b0;

  always #4 clk = ~clk;

  function automatic logic signed [SHIFT_W-1:0] clamp_shift(logic [31:0] v);
    logic signed [SHIFT_W-1:0] s;
    s = v[SHIFT_W-1:0];
    if (s > SHIFT_LIM) s = SHIFT_W'(SHIFT_LIM);
    else if (s < -SHIFT_LIM) s = SHIFT_W'(-SHIFT_LIM);
    return s;
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain(logic [31:0] v);
    logic [GAIN_W-1:0] g;
    g = v[GAIN_W-1:0];
    if (g > GAIN_LIM) g = GAIN_W'(GAIN_LIM);
    return g;
  endfunction

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic bit near_default(longint v, longint target);
    longint d;
    d = v - target;
    if (d < 0) d = -d;
    return d * 1000 < ONE;
  endfunction

  // offset, contrast and color shift; result at scale 255*ONE
  function automatic longint grade_channel(logic [7:0] c, longint shift);
    longint x, z;
    x = longint'(c) * ONE + 255 * longint'(set_bright);
    z = 4 * ((x - HALF_GREY) * longint'(set_contrast) + HALF_GREY * ONE) + shift;
    return floor_quot(z, 4 * ONE);
  endfunction

  function automatic logic [7:0] saturate_channel(longint v, longint lum);
    longint d, num, q;
    d   = W_DEN * v - lum;
    num = lum * ONE + d * longint'(set_sat);
    q   = floor_quot(num, W_DEN * ONE * ONE);
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic pixel_t grade_pixel(pixel_t px);
    longint rv, gv, bv, lum;
    pixel_t res;
    res = px;
    if (near_default(set_bright, 0) && near_default(set_contrast, ONE) &&
        near_default(set_sat, ONE) && near_default(set_temp, 0) &&
        near_default(set_tint, 0)) return res;
    rv  = grade_channel(px.r, SHIFT_K * longint'(set_temp) * ONE);
    gv  = grade_channel(px.g, -SHIFT_K * longint'(set_tint) * ONE);
    bv  = grade_channel(px.b, -SHIFT_K * longint'(set_temp) * ONE);
    lum = W_RED * rv + W_GREEN * gv + W_BLUE * bv;
    res.r = saturate_channel(rv, lum);
    res.g = saturate_channel(gv, lum);
    res.b = saturate_channel(bv, lum);
    return res;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_setting(bit gain, bit near);
    int d;
    d = int'($urandom_range(8)) - 4;
    if (near) return gain ? GAIN_RESET + d : d;
    case ($urandom_range(6))
      0:       return gain ? 0 : -SHIFT_LIM;
      1:       return gain ? GAIN_LIM : SHIFT_LIM;
      2:       return $urandom();
      3:       return gain ? GAIN_RESET + d : d;
      default: return gain ? $urandom_range(GAIN_LIM)
                           : int'($urandom_range(2 * SHIFT_LIM)) - SHIFT_LIM;
    endcase
  endfunction

  function automatic void add_cfg(logic [2:0] sel, logic [31:0] val);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.sel    = sel;
    row.wdata  = val;
    dir_steps.push_back(row);
  endfunction

  function automatic void add_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [7:0] a, logic last, bit known = 1'b0,
                                 logic [7:0] kr = 8'd0, logic [7:0] kg = 8'd0,
                                 logic [7:0] kb = 8'd0);
    step_row_t row;
    row = '{default: '0};
    row.px       = '{r, g, b, a, last};
    row.known    = known;
    row.known_px = '{kr, kg, kb, a, last};
    dir_steps.push_back(row);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("ERROR: %s", msg);
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (graded_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_pixel(pixel_t px, pixel_t want);
    int gap;
    gap = pick_gap();
    graded_q.push_back(want);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.red_in   = px.r;
    in_if.green_in = px.g;
    in_if.blue_in  = px.b;
    in_if.alpha_in = px.a;
    in_if.last_in  = px.last;
    in_if.valid    = 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic cfg_write(logic [2:0] sel, logic [31:0] val);
    drain_pipe();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({sel, 2'b00});
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      REG_BRIGHT:   set_bright   = clamp_shift(val);
      REG_CONTRAST: set_contrast = clamp_gain(val);
      REG_SAT:      set_sat      = clamp_gain(val);
      REG_TEMP:     set_temp     = clamp_shift(val);
      REG_TINT:     set_tint     = clamp_shift(val);
      default:      ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // result side: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end else if (stall_left == 0 && !quiet && $urandom_range(3) == 0) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.red_out, out_if.green_out, out_if.blue_out,
              out_if.alpha_out, out_if.last_out};
      results_seen++;
      if (graded_q.size() == 0) begin
        report_mismatch($sformatf("transfer %0d: result with none expected", results_seen));
      end else begin
        want = graded_q.pop_front();
        if (got.r !== want.r)
          report_mismatch($sformatf("transfer %0d: red %0d, expected %0d",
                                    results_seen, got.r, want.r));
        if (got.g !== want.g)
          report_mismatch($sformatf("transfer %0d: green %0d, expected %0d",
                                    results_seen, got.g, want.g));
        if (got.b !== want.b)
          report_mismatch($sformatf("transfer %0d: blue %0d, expected %0d",
                                    results_seen, got.b, want.b));
        if (got.a !== want.a)
          report_mismatch($sformatf("transfer %0d: alpha %0d, expected %0d",
                                    results_seen, got.a, want.a));
        if (got.last !== want.last)
          report_mismatch($sformatf("transfer %0d: last %0b, expected %0b",
                                    results_seen, got.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    pixel_t px;
    bit     near;

    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.red_in   = '0;
    in_if.green_in = '0;
    in_if.blue_in  = '0;
    in_if.alpha_in = '0;
    in_if.last_in  = 1'b0;
    out_if.ready   = 1'b0;
    set_bright     = '0;
    set_contrast   = GAIN_W'(GAIN_RESET);
    set_sat        = GAIN_W'(GAIN_RESET);
    set_temp       = '0;
    set_tint       = '0;

    // reset defaults: pixels pass untouched
    add_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
    add_px(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255);
    add_px(8'd1, 8'd128, 8'd254, 8'hAA, 1'b0, 1'b1, 8'd1, 8'd128, 8'd254);
    add_px(8'h55, 8'hAA, 8'h0F, 8'h55, 1'b1, 1'b1, 8'h55, 8'hAA, 8'h0F);
    // every setting just inside the bypass window
    add_cfg(REG_BRIGHT, 4);
    add_cfg(REG_CONTRAST, 4092);
    add_cfg(REG_SAT, 4100);
    add_cfg(REG_TEMP, -4);
    add_cfg(REG_TINT, 3);
    add_px(8'd10, 8'd200, 8'd77, 8'd3, 1'b0, 1'b1, 8'd10, 8'd200, 8'd77);
    add_px(8'd255, 8'd0, 8'd128, 8'd250, 1'b1, 1'b1, 8'd255, 8'd0, 8'd128);
    // brightness just outside the window
    add_cfg(REG_BRIGHT, 5);
    add_cfg(REG_CONTRAST, GAIN_RESET);
    add_cfg(REG_SAT, GAIN_RESET);
    add_cfg(REG_TEMP, 0);
    add_cfg(REG_TINT, 0);
    add_px(8'd10, 8'd200, 8'd77, 8'd9, 1'b0);
    add_cfg(REG_BRIGHT, SHIFT_LIM);
    add_px(8'd0, 8'd0, 8'd0, 8'd1, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255);
    add_px(8'd128, 8'd1, 8'd254, 8'd2, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255);
    // out of range, saturates to the negative bound
    add_cfg(REG_BRIGHT, -5000);
    add_px(8'd255, 8'd255, 8'd255, 8'd7, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
    add_cfg(REG_BRIGHT, 0);
    add_cfg(REG_CONTRAST, 0);
    add_px(8'd0, 8'd255, 8'd13, 8'd77, 1'b1, 1'b1, 8'd127, 8'd127, 8'd127);
    add_cfg(REG_CONTRAST, 32'h0000_7FFF);
    add_px(8'd0, 8'd255, 8'd128, 8'd0, 1'b0);
    add_px(8'd100, 8'd150, 8'd200, 8'd255, 1'b0);
    add_cfg(REG_CONTRAST, GAIN_RESET);
    add_cfg(REG_SAT, 0);
    add_px(8'd255, 8'd0, 8'd0, 8'd5, 1'b0);
    add_px(8'd0, 8'd255, 8'd0, 8'd6, 1'b1);
    add_cfg(REG_SAT, 32'hFFFF_FFFF);
    add_px(8'd200, 8'd100, 8'd50, 8'd8, 1'b0);
    add_cfg(REG_SAT, GAIN_RESET);
    add_cfg(REG_TEMP, SHIFT_LIM);
    add_px(8'd0, 8'd128, 8'd255, 8'd11, 1'b0);
    add_cfg(REG_TEMP, 32'h0000_2000);
    add_px(8'd255, 8'd128, 8'd0, 8'd12, 1'b1);
    add_cfg(REG_TEMP, 0);
    add_cfg(REG_TINT, SHIFT_LIM);
    add_px(8'd128, 8'd128, 8'd128, 8'd13, 1'b0);
    add_cfg(REG_TINT, -SHIFT_LIM);
    add_px(8'd60, 8'd200, 8'd90, 8'd14, 1'b0);
    // unmapped register: tint must stay put
    add_cfg(REG_SPARE, 0);
    add_px(8'd60, 8'd200, 8'd90, 8'd15, 1'b1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_steps[k]) begin
      if (dir_steps[k].is_cfg) cfg_write(dir_steps[k].sel, dir_steps[k].wdata);
      else if (dir_steps[k].known) send_pixel(dir_steps[k].px, dir_steps[k].known_px);
      else send_pixel(dir_steps[k].px, grade_pixel(dir_steps[k].px));
    end

    for (int p = 0; p < PHASES; p++) begin
      near = (p == 4);
      cfg_write(REG_BRIGHT, rand_setting(1'b0, near));
      cfg_write(REG_CONTRAST, rand_setting(1'b1, near));
      cfg_write(REG_SAT, rand_setting(1'b1, near));
      cfg_write(REG_TEMP, rand_setting(1'b0, near));
      cfg_write(REG_TINT, rand_setting(1'b0, near));
      if ($urandom_range(3) == 0) cfg_write(REG_SPARE, $urandom());
      quiet = (p == 1 || p == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        px.r    = pick_channel();
        px.g    = pick_channel();
        px.b    = pick_channel();
        px.a    = 8'($urandom());
        px.last = ($urandom_range(7) == 0);
        send_pixel(px, grade_pixel(px));
        // long result-side hold-off while input keeps coming
        if (p == 6 && i == 5) hold_req = HOLD_CYCLES;
      end
      quiet = 1'b0;
    end

    drain_pipe();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
